FILE: rtl/core/mfhd_pkg.sv
// Shared types, codes and helpers for the MQTT fixed-header deframer.
package mfhd_pkg;

    localparam int unsigned MFHD_MAX_LEN_BYTES   = 4;
    localparam int unsigned MFHD_LEN_W           = 28;
    localparam int unsigned MFHD_MAXPKT_W        = 17;
    localparam int unsigned MFHD_CNT_W           = 3;
    localparam logic [MFHD_MAXPKT_W-1:0] MFHD_MAXPKT_RESET = 17'd1024;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY      = 2'd0,
        ST_DONE      = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        t_phase                  phase;
        logic [MFHD_LEN_W-1:0]   length_accum;
        logic [MFHD_CNT_W-1:0]   length_byte_count;
        logic [3:0]              held_kind;
        logic [MFHD_LEN_W-1:0]   body_left;
    } t_state;

    typedef struct packed {
        t_status               frame_status;
        logic [3:0]            packet_kind;
        logic [MFHD_LEN_W-1:0] body_length;
    } t_result;

    // Bytes in the shortest base-128 encoding of a remaining length.
    function automatic logic [2:0] encoded_size(input logic [MFHD_LEN_W-1:0] v);
        logic [2:0] n;
        if (v < 28'd128) begin
            n = 3'd1;
        end else if (v < 28'd16384) begin
            n = 3'd2;
        end else if (v < 28'd2097152) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/mfhd_step.sv
// Next-state and status logic for one received byte of the deframer.
module mfhd_step
    import mfhd_pkg::*;
#(
    parameter int unsigned MAX_LENGTH_BYTES = MFHD_MAX_LEN_BYTES
) (
    input  t_state                     i_state,
    input  logic [7:0]                 i_rx_byte,
    input  logic [MFHD_MAXPKT_W-1:0]   i_max_bytes,
    output t_state                     o_state,
    output t_result                    o_result
);

    logic [MFHD_LEN_W-1:0] w_digit;
    logic [MFHD_LEN_W-1:0] w_accum;
    logic [MFHD_CNT_W-1:0] w_count;
    logic [MFHD_LEN_W:0]   w_total;
    logic [MFHD_LEN_W-1:0] w_left;

    // Each length byte lands 7 bits above the previous one.
    always_comb begin
        case (i_state.length_byte_count[1:0])
            2'd0:    w_digit = {21'd0, i_rx_byte[6:0]};
            2'd1:    w_digit = {14'd0, i_rx_byte[6:0], 7'd0};
            2'd2:    w_digit = {7'd0, i_rx_byte[6:0], 14'd0};
            default: w_digit = {i_rx_byte[6:0], 21'd0};
        endcase
    end

    assign w_accum = i_state.length_accum + w_digit;
    assign w_count = i_state.length_byte_count + 3'd1;
    assign w_total = {1'b0, w_accum} + {{(MFHD_LEN_W-2){1'b0}}, encoded_size(w_accum)}
                     + {{MFHD_LEN_W{1'b0}}, 1'b1};
    assign w_left  = i_state.body_left - {{(MFHD_LEN_W-1){1'b0}}, 1'b1};

    always_comb begin
        o_state  = i_state;
        o_result = '{frame_status: ST_BUSY, packet_kind: 4'd0, body_length: '0};
        case (i_state.phase)
            PH_LENGTH: begin
                o_state.length_accum      = w_accum;
                o_state.length_byte_count = w_count;
                if (i_rx_byte[7]) begin
                    if (w_count >= MFHD_CNT_W'(MAX_LENGTH_BYTES)) begin
                        o_state.phase         = PH_HEADER;
                        o_result.frame_status = ST_MALFORMED;
                    end
                end else if (w_total > {{(MFHD_LEN_W+1-MFHD_MAXPKT_W){1'b0}}, i_max_bytes}) begin
                    o_state.phase         = PH_HEADER;
                    o_result.frame_status = ST_OVERFLOW;
                    o_result.body_length  = w_accum;
                end else if (w_accum == '0) begin
                    o_state.phase         = PH_HEADER;
                    o_result.frame_status = ST_DONE;
                    o_result.packet_kind  = i_state.held_kind;
                end else begin
                    o_state.body_left = w_accum;
                    o_state.phase     = PH_BODY;
                end
            end
            PH_BODY: begin
                o_state.body_left = w_left;
                if (w_left == '0) begin
                    o_state.phase         = PH_HEADER;
                    o_result.frame_status = ST_DONE;
                    o_result.packet_kind  = i_state.held_kind;
                    o_result.body_length  = i_state.length_accum;
                end
            end
            default: begin
                // Header byte; the unused phase code is treated the same way.
                o_state.held_kind         = i_rx_byte[7:4];
                o_state.length_accum      = '0;
                o_state.length_byte_count = '0;
                o_state.body_left         = '0;
                o_state.phase             = PH_LENGTH;
            end
        endcase
    end

endmodule

FILE: rtl/core/mqtt_fixed_header_deframer.sv
// Top level of the MQTT fixed-header deframer: framing state, config and output skid.
//
//  Channel   Direction  Handshake          Payload
//  rx        in         i_valid / o_stall  i_rx_byte
//  status    out        o_valid / i_stall  o_frame_status, o_packet_kind, o_body_length
//  config    in         i_cfg_we           i_cfg_wdata (max_packet_bytes)
//
// One byte is accepted per cycle while o_stall is low, and one status beat leaves per
// cycle while i_stall is low; each beat is registered in the output register or skid.
// The framing state updates in the cycle a byte is accepted, so the next byte sees it.
// A two-entry output stage (register plus skid) keeps o_stall registered; it rises
// only after the output has been stalled while a second beat arrived.
// Reset is synchronous and returns the framer to the header state with max 1024.
module mqtt_fixed_header_deframer
    import mfhd_pkg::*;
#(
    parameter int unsigned MAX_LENGTH_BYTES = MFHD_MAX_LEN_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_rx_byte,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_frame_status,
    output logic [3:0]               o_packet_kind,
    output logic [MFHD_LEN_W-1:0]    o_body_length,
    input  logic                     i_cfg_we,
    input  logic [MFHD_MAXPKT_W-1:0] i_cfg_wdata
);

    t_state                   r_state;
    t_state                   n_state;
    t_result                  n_result;
    t_result                  r_out;
    t_result                  r_skid;
    logic                     r_out_valid;
    logic                     r_skid_valid;
    logic [MFHD_MAXPKT_W-1:0] r_max_bytes;
    logic                     w_accept;
    logic                     w_out_free;

    mfhd_step #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_step (
        .i_state    (r_state),
        .i_rx_byte  (i_rx_byte),
        .i_max_bytes(r_max_bytes),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    assign w_accept   = i_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_max_bytes  <= MFHD_MAXPKT_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_bytes <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_state <= n_state;
            end
            if (w_out_free) begin
                r_out_valid  <= r_skid_valid || w_accept;
                r_skid_valid <= 1'b0;
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= n_result;
            end
        end else if (w_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_frame_status = r_out.frame_status;
    assign o_packet_kind  = r_out.packet_kind;
    assign o_body_length  = r_out.body_length;

endmodule

FILE: rtl/core/mfhd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
module mfhd_checker
    import mfhd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic [1:0]               o_frame_status,
    input logic [3:0]               o_packet_kind,
    input logic [MFHD_LEN_W-1:0]    o_body_length
);

    // The type nibble is only reported on a completed packet.
    a_kind_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame_status != ST_DONE) |-> o_packet_kind == 4'd0)
        else $error("packet kind set on a beat that is not a completion");

    // Busy and malformed beats carry no length.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_frame_status == ST_BUSY) || (o_frame_status == ST_MALFORMED))
        |-> o_body_length == '0)
        else $error("body length set on a busy or malformed beat");

    // Back-pressure toward the byte source only appears after a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall && i_valid))
        else $error("input stall raised without a stalled output beat");

    // A stalled status beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_status)
        && $stable(o_packet_kind) && $stable(o_body_length))
        else $error("stalled status beat changed");

endmodule

bind mqtt_fixed_header_deframer mfhd_checker u_mfhd_checker (.*);
